// File: src/acfp_pkg.sv
// Shared types, character codes and helpers for the ASCII CAN frame parser.
`timescale 1ns / 1ps

package acfp_pkg;

   // Default longest line, in non-terminator characters
   localparam int MAX_LINE_DEF = 64;
   // Most payload bytes in one frame
   localparam int MAX_BYTES = 8;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [2:0] {
      PH_SEEK = 3'd0,
      PH_KIND = 3'd1,
      PH_HDR  = 3'd2,
      PH_DATA = 3'd3,
      PH_DONE = 3'd4,
      PH_BAD  = 3'd5
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic        frame_ok;
      logic [31:0] can_header;
      logic [3:0]  data_count;
      logic [63:0] payload;
   } rsp_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: src/acfp_parser.sv
// Per-character line state and frame decode, one item per cycle while take is high.
`timescale 1ns / 1ps

module acfp_parser #(
   parameter int MAX_LINE = acfp_pkg::MAX_LINE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        rx_char,
   output logic              res_valid,
   output acfp_pkg::rsp_type res
);

   localparam int LEN_W = $clog2(MAX_LINE + 1);

   acfp_pkg::phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]    line_length_ff, line_length_in;
   logic [31:0]         header_ff, header_in;
   logic                digit_seen_ff, digit_seen_in;
   logic [63:0]         payload_ff, payload_in;
   logic [3:0]          byte_count_ff, byte_count_in;
   logic [3:0]          high_nibble_ff, high_nibble_in;
   logic                pending_ff, pending_in;

   acfp_pkg::hex_type   hx;
   logic                clear_line;
   logic                ok;
   logic [7:0]          data_byte;

   always_comb begin
      phase_in       = phase_ff;
      line_length_in = line_length_ff;
      header_in      = header_ff;
      digit_seen_in  = digit_seen_ff;
      payload_in     = payload_ff;
      byte_count_in  = byte_count_ff;
      high_nibble_in = high_nibble_ff;
      pending_in     = pending_ff;
      hx             = acfp_pkg::hex_decode(rx_char);
      clear_line     = 1'b0;
      res_valid      = 1'b0;
      res            = '0;
      ok             = (phase_ff == acfp_pkg::PH_DATA) || (phase_ff == acfp_pkg::PH_DONE);
      data_byte      = {high_nibble_ff, hx.value};

      if (take) begin
         priority if (rx_char == acfp_pkg::CH_SEMI) begin
            res_valid      = 1'b1;
            res.frame_ok   = ok;
            res.can_header = ok ? header_ff : 32'd0;
            res.data_count = ok ? byte_count_ff : 4'd0;
            res.payload    = ok ? payload_ff : 64'd0;
            clear_line     = 1'b1;
         end else if (rx_char == acfp_pkg::CH_CR || rx_char == acfp_pkg::CH_LF) begin
            clear_line = 1'b1;
         end else if (line_length_ff >= LEN_W'(MAX_LINE)) begin
            // drop the overflowing character along with the line
            clear_line = 1'b1;
         end else begin
            line_length_in = line_length_ff + 1'b1;
            unique case (phase_ff)
               acfp_pkg::PH_SEEK: begin
                  if (rx_char == acfp_pkg::CH_COLON) phase_in = acfp_pkg::PH_KIND;
               end
               acfp_pkg::PH_KIND: begin
                  phase_in = (rx_char == acfp_pkg::CH_X || rx_char == acfp_pkg::CH_S)
                             ? acfp_pkg::PH_HDR : acfp_pkg::PH_BAD;
               end
               acfp_pkg::PH_HDR: begin
                  priority if (hx.valid) begin
                     header_in     = {header_ff[27:0], hx.value};
                     digit_seen_in = 1'b1;
                  end else if (digit_seen_ff && rx_char == acfp_pkg::CH_R) begin
                     phase_in = acfp_pkg::PH_DONE;
                  end else if (digit_seen_ff && rx_char == acfp_pkg::CH_N) begin
                     phase_in = acfp_pkg::PH_DATA;
                  end else begin
                     phase_in = acfp_pkg::PH_BAD;
                  end
               end
               acfp_pkg::PH_DATA: begin
                  priority if (!hx.valid) begin
                     // non-hex character ends collection, dropping any incomplete pair; frame stays valid
                     pending_in = 1'b0;
                     phase_in   = acfp_pkg::PH_DONE;
                  end else if (!pending_ff) begin
                     high_nibble_in = hx.value;
                     pending_in     = 1'b1;
                  end else begin
                     for (int i = 0; i < 8; i++) begin
                        if (byte_count_ff[2:0] == 3'(i)) payload_in[63-8*i -: 8] = data_byte;
                     end
                     byte_count_in = byte_count_ff + 1'b1;
                     pending_in    = 1'b0;
                     if (byte_count_in >= 4'(acfp_pkg::MAX_BYTES)) phase_in = acfp_pkg::PH_DONE;
                  end
               end
               acfp_pkg::PH_DONE: begin
                  phase_in = acfp_pkg::PH_DONE;
               end
               default: begin
                  phase_in = acfp_pkg::PH_BAD;
               end
            endcase
         end
      end

      if (clear_line) begin
         phase_in       = acfp_pkg::PH_SEEK;
         line_length_in = '0;
         header_in      = 32'd0;
         digit_seen_in  = 1'b0;
         payload_in     = 64'd0;
         byte_count_in  = 4'd0;
         high_nibble_in = 4'd0;
         pending_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= acfp_pkg::PH_SEEK;
         line_length_ff <= '0;
         header_ff      <= 32'd0;
         digit_seen_ff  <= 1'b0;
         payload_ff     <= 64'd0;
         byte_count_ff  <= 4'd0;
         high_nibble_ff <= 4'd0;
         pending_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         line_length_ff <= line_length_in;
         header_ff      <= header_in;
         digit_seen_ff  <= digit_seen_in;
         payload_ff     <= payload_in;
         byte_count_ff  <= byte_count_in;
         high_nibble_ff <= high_nibble_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

// File: src/acfp_out_reg.sv
// Result register that holds a decoded frame item until the receiver takes it.
`timescale 1ns / 1ps

module acfp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  acfp_pkg::rsp_type load_data,
   input  logic              out_stall,
   output logic              out_valid,
   output acfp_pkg::rsp_type out_data
);

   logic              valid_ff, valid_in;
   acfp_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      priority if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end else begin
         // hold the waiting item
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: src/ascii_can_frame_parser_top.sv
// Top level of the ASCII CAN frame parser.
// Usage:
//   req channel: one received character per item on req_rx_char. The block
//   takes an item every cycle while no finished frame is held up on rsp.
//   rsp channel: one item per ';' character, carrying rsp_frame_ok, the
//   header, the payload byte count and the payload (first byte in 63:56).
//   Header, count and payload read zero when rsp_frame_ok is low.
// Output: an accepted ';' is registered and reaches rsp in the next cycle.
// Throughput: one character per cycle while req_stall is low; the result
//   register loads in the same cycle it is drained.
// Stall: while rsp_valid is high and rsp_stall is high, the result holds and
//   req_stall is raised, so no character is taken.
// Reset: synchronous; clears the line state (waiting for ':') and empties
//   the result register. No result is pending after reset.
// CR or LF discards the line; a character beyond MAX_LINE discards the line
//   and is itself dropped.
`timescale 1ns / 1ps

module ascii_can_frame_parser_top #(
   parameter int MAX_LINE = acfp_pkg::MAX_LINE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [31:0] rsp_can_header,
   output logic [3:0]  rsp_data_count,
   output logic [63:0] rsp_payload
);

   logic              take;
   logic              res_valid;
   acfp_pkg::rsp_type res;
   acfp_pkg::rsp_type out_data;

   // hold input only while a finished item waits on a stalled receiver
   assign req_stall = rsp_valid && rsp_stall;
   assign take      = req_valid && !req_stall;

   acfp_parser #(
      .MAX_LINE(MAX_LINE)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_char  (req_rx_char),
      .res_valid(res_valid),
      .res      (res)
   );

   acfp_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .load_data(res),
      .out_stall(rsp_stall),
      .out_valid(rsp_valid),
      .out_data (out_data)
   );

   assign rsp_frame_ok   = out_data.frame_ok;
   assign rsp_can_header = out_data.can_header;
   assign rsp_data_count = out_data.data_count;
   assign rsp_payload    = out_data.payload;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data_count <= 4'(acfp_pkg::MAX_BYTES))
      else $error("data count beyond byte limit");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ok) |->
         (rsp_can_header == 32'd0 && rsp_data_count == 4'd0 && rsp_payload == 64'd0))
      else $error("invalid frame carries nonzero fields");

   a_semi_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (take && req_rx_char == acfp_pkg::CH_SEMI) |=> rsp_valid)
      else $error("terminator accepted without a result");

   a_other_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (take && req_rx_char != acfp_pkg::CH_SEMI) |=> !rsp_valid)
      else $error("result appeared without a terminator");

endmodule
